FILE: src/pfb_pkg.sv
package pfb_pkg;

    localparam int DEF_PAGES   = 8;
    localparam int DEF_COLUMNS = 128;

    localparam int LINE_W    = 8;
    localparam int COL_W     = 8;
    localparam int WIDTH_W   = 8;
    localparam int HEIGHT_W  = 4;
    localparam int PIX_W     = 8;
    localparam int RPAGE_W   = 3;
    localparam int OP_W      = 2;
    localparam int IN_DATA_W = 40;

    localparam int PAGE_SUM_W = 5;
    localparam int COL_SUM_W  = 9;

    typedef enum logic [OP_W-1:0] {
        OP_START = 2'd0,
        OP_DATA  = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef struct packed {
        logic start_load;
        logic data_upper;
        logic data_lower;
        logic read_issue;
        logic out_load;
        logic clear_step;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic blit_active;
        logic out_full;
    } sts_t;

endpackage

FILE: src/pfb_ctrl.sv
module pfb_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [1:0]    in_op,
    output logic          in_ready,
    input  logic          out_ready,
    input  pfb_pkg::sts_t sts,
    output pfb_pkg::cmd_t cmd
);
    import pfb_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DATA_LO,
        ST_READ_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;
    op_t    op;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign op       = op_t'(in_op);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (op)
                        OP_START:
                        begin
                            cmd.start_load = 1'b1;
                        end
                        OP_DATA:
                        begin
                            if (sts.blit_active)
                            begin
                                cmd.data_upper = 1'b1;
                                state_next     = ST_DATA_LO;
                            end
                        end
                        OP_READ:
                        begin
                            cmd.read_issue = 1'b1;
                            state_next     = ST_READ_OUT;
                        end
                        OP_CLEAR:
                        begin
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DATA_LO:
            begin
                cmd.data_lower = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_READ_OUT:
            begin
                if (!sts.out_full || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: src/pfb_datapath.sv
module pfb_datapath #(
    parameter int PAGES   = pfb_pkg::DEF_PAGES,
    parameter int COLUMNS = pfb_pkg::DEF_COLUMNS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pfb_pkg::cmd_t                 cmd,
    output pfb_pkg::sts_t                 sts,
    input  logic [pfb_pkg::LINE_W-1:0]    start_line,
    input  logic [pfb_pkg::COL_W-1:0]     start_column,
    input  logic [pfb_pkg::WIDTH_W-1:0]   image_width,
    input  logic [pfb_pkg::HEIGHT_W-1:0]  image_pages,
    input  logic [pfb_pkg::PIX_W-1:0]     pixel_byte,
    input  logic [pfb_pkg::RPAGE_W-1:0]   read_page,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [pfb_pkg::PIX_W-1:0]     read_data
);
    import pfb_pkg::*;

    localparam int DEPTH = PAGES * COLUMNS;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = $clog2(PAGES * 8);
    localparam int CW    = $clog2(COLUMNS);

    logic [PIX_W-1:0]    mem [DEPTH];

    logic [LW-1:0]       origin_line_reg;
    logic [CW-1:0]       origin_column_reg;
    logic [WIDTH_W-1:0]  blit_width_reg;
    logic [HEIGHT_W-1:0] blit_pages_reg;
    logic [HEIGHT_W-1:0] row_counter_reg;
    logic [WIDTH_W-1:0]  column_counter_reg;
    logic                blit_active_reg;

    logic [AW-1:0]       clr_cnt_reg;
    logic [AW-1:0]       lo_addr_reg;
    logic                lo_ok_reg;
    logic [PIX_W-1:0]    lo_byte_reg;
    logic                merge_reg;
    logic [PIX_W-1:0]    rd_data_reg;
    logic                rd_ok_reg;
    logic                out_valid_reg;
    logic [PIX_W-1:0]    out_data_reg;

    logic                  start_ok;
    logic [PAGE_SUM_W-1:0] page_lo;
    logic [PAGE_SUM_W-1:0] page_hi;
    logic [COL_SUM_W-1:0]  col_sum;
    logic [2*PIX_W-1:0]    shifted;
    logic                  col_ok;
    logic                  lo_ok;
    logic                  up_ok;
    logic [AW-1:0]         lo_addr;
    logic [AW-1:0]         up_addr;
    logic                  rd_ok;
    logic [AW-1:0]         rq_addr;
    logic                  we;
    logic [AW-1:0]         wa;
    logic [PIX_W-1:0]      wd;
    logic                  re;
    logic [AW-1:0]         ra;
    logic [WIDTH_W:0]      col_inc;
    logic [HEIGHT_W:0]     row_inc;

    assign start_ok = ({1'b0, start_line} < 9'(PAGES * 8)) &&
                      ({1'b0, start_column} < 9'(COLUMNS));

    assign page_lo = PAGE_SUM_W'(origin_line_reg >> 3) + PAGE_SUM_W'(row_counter_reg);
    assign page_hi = page_lo + PAGE_SUM_W'(1);
    assign col_sum = COL_SUM_W'(origin_column_reg) + COL_SUM_W'(column_counter_reg);
    assign shifted = {{PIX_W{1'b0}}, pixel_byte} << origin_line_reg[2:0];

    assign col_ok  = col_sum < COL_SUM_W'(COLUMNS);
    assign lo_ok   = col_ok && (page_lo < PAGE_SUM_W'(PAGES));
    assign up_ok   = col_ok && (page_hi < PAGE_SUM_W'(PAGES));
    assign lo_addr = AW'(32'(page_lo) * COLUMNS + 32'(col_sum));
    assign up_addr = AW'(32'(page_hi) * COLUMNS + 32'(col_sum));

    assign rd_ok   = (PAGE_SUM_W'(read_page) < PAGE_SUM_W'(PAGES)) &&
                     ({1'b0, start_column} < 9'(COLUMNS));
    assign rq_addr = AW'(32'(read_page) * COLUMNS + 32'(start_column));

    assign col_inc = {1'b0, column_counter_reg} + (WIDTH_W+1)'(1);
    assign row_inc = {1'b0, row_counter_reg} + (HEIGHT_W+1)'(1);

    always_comb
    begin
        we = 1'b0;
        wa = '0;
        wd = '0;
        if (cmd.clear_step)
        begin
            we = 1'b1;
            wa = clr_cnt_reg;
        end
        else if (cmd.data_upper)
        begin
            we = up_ok;
            wa = up_addr;
            wd = shifted[2*PIX_W-1:PIX_W];
        end
        else if (cmd.data_lower)
        begin
            we = lo_ok_reg;
            wa = lo_addr_reg;
            wd = merge_reg ? (rd_data_reg | lo_byte_reg) : lo_byte_reg;
        end
    end

    assign re = cmd.data_upper || cmd.read_issue;
    assign ra = cmd.data_upper ? lo_addr : rq_addr;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (re)
        begin
            rd_data_reg <= mem[ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.data_upper)
        begin
            lo_addr_reg <= lo_addr;
            lo_ok_reg   <= lo_ok;
            lo_byte_reg <= shifted[PIX_W-1:0];
            merge_reg   <= (row_counter_reg != '0);
        end
        if (cmd.read_issue)
        begin
            rd_ok_reg <= rd_ok;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= rd_ok_reg ? rd_data_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_line_reg    <= '0;
            origin_column_reg  <= '0;
            blit_width_reg     <= '0;
            blit_pages_reg     <= '0;
            row_counter_reg    <= '0;
            column_counter_reg <= '0;
            blit_active_reg    <= 1'b0;
            clr_cnt_reg        <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.start_load && start_ok)
            begin
                origin_line_reg    <= LW'(start_line);
                origin_column_reg  <= CW'(start_column);
                blit_width_reg     <= image_width;
                blit_pages_reg     <= image_pages;
                row_counter_reg    <= '0;
                column_counter_reg <= '0;
                blit_active_reg    <= (image_width != '0) && (image_pages != '0);
            end
            if (cmd.data_lower)
            begin
                if (col_inc >= {1'b0, blit_width_reg})
                begin
                    column_counter_reg <= '0;
                    row_counter_reg    <= row_inc[HEIGHT_W-1:0];
                    if (row_inc >= {1'b0, blit_pages_reg})
                    begin
                        blit_active_reg <= 1'b0;
                    end
                end
                else
                begin
                    column_counter_reg <= col_inc[WIDTH_W-1:0];
                end
            end
            if (cmd.clear_step)
            begin
                clr_cnt_reg <= sts.clear_last ? '0 : clr_cnt_reg + AW'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.clear_last  = (clr_cnt_reg == AW'(DEPTH - 1));
    assign sts.blit_active = blit_active_reg;
    assign sts.out_full    = out_valid_reg;

    assign out_valid = out_valid_reg;
    assign read_data = out_data_reg;

endmodule

FILE: src/page_framebuffer_blitter.sv
// channel   dir  tdata                                            tuser
// s_axis    in   start_line, start_column, image_width,          op
//                image_pages, pixel_byte, read_page
// m_axis    out  read_data                                        -
//
// a data byte writes the upper page while the lower byte is read, then writes
// the lower byte; a read fetches the byte, then loads the output register
// after reset and after a clear request the memory is zeroed one byte a cycle,
// all PAGES*COLUMNS bytes (1024 by default), with no request taken meanwhile
// a read waits in place while the output register holds a result not yet taken
module page_framebuffer_blitter #(
    parameter int PAGES   = pfb_pkg::DEF_PAGES,
    parameter int COLUMNS = pfb_pkg::DEF_COLUMNS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // start_line, start_column, image_width, image_pages, pixel_byte, read_page
    input  logic [pfb_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // op
    input  logic [pfb_pkg::OP_W-1:0]        s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // read_data
    output logic [pfb_pkg::PIX_W-1:0]       m_axis_tdata
);
    import pfb_pkg::*;

    cmd_t cmd;
    sts_t sts;

    pfb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_op     (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    pfb_datapath #(
        .PAGES   (PAGES),
        .COLUMNS (COLUMNS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .start_line   (s_axis_tdata[7:0]),
        .start_column (s_axis_tdata[15:8]),
        .image_width  (s_axis_tdata[23:16]),
        .image_pages  (s_axis_tdata[27:24]),
        .pixel_byte   (s_axis_tdata[35:28]),
        .read_page    (s_axis_tdata[38:36]),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .read_data    (m_axis_tdata)
    );

endmodule
